>>> design/mmhs_pkg.sv
package mmhs_pkg;

   localparam int MOTOR_W    = 2;
   localparam int STEPS_W    = 16;
   localparam int PHASE_W    = 3;
   localparam int COIL_W     = 4;
   // Motors that the enable register, busy mask and coil field can describe.
   localparam int SHOWN_MOTORS = 2;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      KIND_TICK  = 2'd0,
      KIND_MOVE  = 2'd1,
      KIND_STOP  = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   // Half-step coil pattern, one entry per phase index.
   function automatic logic [COIL_W-1:0] half_step_coils(input logic [PHASE_W-1:0] idx);
      logic [COIL_W-1:0] coils;
      case (idx)
         3'd0: coils = 4'b0001;
         3'd1: coils = 4'b0011;
         3'd2: coils = 4'b0010;
         3'd3: coils = 4'b0110;
         3'd4: coils = 4'b0100;
         3'd5: coils = 4'b1100;
         3'd6: coils = 4'b1000;
         3'd7: coils = 4'b1001;
         default: coils = 4'b0000;
      endcase
      return coils;
   endfunction

endpackage

>>> design/multi_motor_half_step_sequencer_unit.sv
// Half-step sequencer for several four-coil unipolar stepper motors.
// Request channel (req_): tuser carries the item kind (tick, move, stop,
// status query); tdata carries motor index, step count and direction.
// Response channel (rsp_): exactly one item per request, giving the error
// status, the busy mask, the coil drive bits and the tick running flag,
// all as they stand after the request has been applied.
// Configuration channel (csr_): writes the motor enable mask; it is always
// ready and should only be written while no request is in flight.
// An accepted request passes through the request register and then the
// response register, where the motor state is updated; it moves on when
// the response register is empty or its item is being taken.
// Throughput is one item per cycle while the receiver takes each response.
// When the receiver stalls, the response register holds its item and the
// request register can still take one more item, after which req_tready
// drops until the response is taken.
// Reset clears all motor counters, phases, directions, coils, the running
// flag, the enable mask and both valid flags.
module multi_motor_half_step_sequencer_unit #(
   parameter int NUM_MOTORS = 2
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // motor [1:0], steps [17:2], reverse [18], zero fill above
   input  logic [mmhs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // kind [1:0]
   input  logic [1:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // status [0], busy_mask [2:1], coil_bits [10:3], running [11], zero fill
   output logic [mmhs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mmhs_pkg::SHOWN_MOTORS-1:0] csr_data
);

   localparam int PW = mmhs_pkg::PHASE_W;
   localparam int SW = mmhs_pkg::STEPS_W;
   localparam int CW = mmhs_pkg::COIL_W;
   localparam int EW = mmhs_pkg::SHOWN_MOTORS;

   logic [EW-1:0] enable_ff;

   // Request register
   logic                          in_valid_ff;
   mmhs_pkg::kind_type            in_kind_ff;
   logic [mmhs_pkg::MOTOR_W-1:0]  in_motor_ff;
   logic [SW-1:0]                 in_steps_ff;
   logic                          in_reverse_ff;

   // Motor state
   logic [PW-1:0] phase_ff   [NUM_MOTORS];
   logic [PW-1:0] phase_in   [NUM_MOTORS];
   logic [SW-1:0] steps_ff   [NUM_MOTORS];
   logic [SW-1:0] steps_in   [NUM_MOTORS];
   logic          reverse_ff [NUM_MOTORS];
   logic          reverse_in [NUM_MOTORS];
   logic [CW-1:0] coil_ff    [NUM_MOTORS];
   logic [CW-1:0] coil_in    [NUM_MOTORS];
   logic          running_ff;
   logic          running_in;

   // Response register
   logic                          rsp_valid_ff;
   logic [mmhs_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic [mmhs_pkg::RSP_DATA_W-1:0] rsp_data_in;

   logic                  advance;
   logic [NUM_MOTORS-1:0] usable;
   logic [NUM_MOTORS-1:0] stepping;
   logic [NUM_MOTORS-1:0] busy_next;
   logic                  target_ok;
   logic                  status_in;
   logic [EW-1:0]         busy_out;
   logic [EW*CW-1:0]      coils_out;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= '0;
      end else if (csr_valid) begin
         enable_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_kind_ff    <= mmhs_pkg::kind_type'(req_tuser);
         in_motor_ff   <= req_tdata[1:0];
         in_steps_ff   <= req_tdata[17:2];
         in_reverse_ff <= req_tdata[18];
      end
   end

   // Enabled motors that exist; motors beyond the enable register never move.
   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         usable[m]   = (m < EW) && enable_ff[m % EW];
         stepping[m] = usable[m] && (steps_ff[m] != '0);
      end
   end

   always_comb begin
      target_ok = 1'b0;
      for (int m = 0; m < NUM_MOTORS; m++) begin
         if (int'(in_motor_ff) == m && usable[m]) begin
            target_ok = 1'b1;
         end
      end
   end

   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         phase_in[m]   = phase_ff[m];
         steps_in[m]   = steps_ff[m];
         reverse_in[m] = reverse_ff[m];
         coil_in[m]    = coil_ff[m];
      end
      running_in = running_ff;
      status_in  = 1'b0;
      case (in_kind_ff)
         mmhs_pkg::KIND_TICK: begin
            if (running_ff) begin
               for (int m = 0; m < NUM_MOTORS; m++) begin
                  if (stepping[m]) begin
                     phase_in[m] = reverse_ff[m] ? phase_ff[m] - PW'(1)
                                                 : phase_ff[m] + PW'(1);
                     coil_in[m]  = mmhs_pkg::half_step_coils(phase_in[m]);
                     steps_in[m] = steps_ff[m] - SW'(1);
                  end
               end
               // No motor left to step: park the coils of the enabled motors and stop the tick.
               if (stepping == '0) begin
                  running_in = 1'b0;
                  for (int m = 0; m < NUM_MOTORS; m++) begin
                     if (usable[m]) begin
                        coil_in[m] = '0;
                     end
                  end
               end
            end
         end
         mmhs_pkg::KIND_MOVE: begin
            if (!target_ok || in_steps_ff == '0) begin
               status_in = 1'b1;
            end else begin
               for (int m = 0; m < NUM_MOTORS; m++) begin
                  if (int'(in_motor_ff) == m) begin
                     reverse_in[m] = in_reverse_ff;
                     steps_in[m]   = in_steps_ff;
                  end
               end
               running_in = 1'b1;
            end
         end
         mmhs_pkg::KIND_STOP: begin
            if (!target_ok) begin
               status_in = 1'b1;
            end else begin
               for (int m = 0; m < NUM_MOTORS; m++) begin
                  if (int'(in_motor_ff) == m) begin
                     steps_in[m] = '0;
                     coil_in[m]  = '0;
                  end
               end
               if (busy_next == '0) begin
                  running_in = 1'b0;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Busy after the stop: the stopped motor is cleared, the rest are as they are.
   always_comb begin
      for (int m = 0; m < NUM_MOTORS; m++) begin
         busy_next[m] = (steps_ff[m] != '0) && (int'(in_motor_ff) != m);
      end
   end

   always_comb begin
      busy_out  = '0;
      coils_out = '0;
      for (int m = 0; m < EW; m++) begin
         if (m < NUM_MOTORS) begin
            busy_out[m]          = steps_in[m % NUM_MOTORS] != '0;
            coils_out[m*CW +: CW] = coil_in[m % NUM_MOTORS];
         end
      end
      rsp_data_in = '0;
      rsp_data_in[0]    = status_in;
      rsp_data_in[2:1]  = busy_out;
      rsp_data_in[10:3] = coils_out;
      rsp_data_in[11]   = running_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int m = 0; m < NUM_MOTORS; m++) begin
            phase_ff[m]   <= '0;
            steps_ff[m]   <= '0;
            reverse_ff[m] <= 1'b0;
            coil_ff[m]    <= '0;
         end
         running_ff <= 1'b0;
      end else if (advance) begin
         for (int m = 0; m < NUM_MOTORS; m++) begin
            phase_ff[m]   <= phase_in[m];
            steps_ff[m]   <= steps_in[m];
            reverse_ff[m] <= reverse_in[m];
            coil_ff[m]    <= coil_in[m];
         end
         running_ff <= running_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

`ifndef SYNTHESIS
   a_move_starts_tick: assert property (@(posedge clock) disable iff (reset)
      advance && in_kind_ff == mmhs_pkg::KIND_MOVE && !status_in |=> rsp_data_ff[11])
      else $error("accepted move did not leave the tick running");

   a_no_error_on_tick_query: assert property (@(posedge clock) disable iff (reset)
      advance && (in_kind_ff == mmhs_pkg::KIND_TICK || in_kind_ff == mmhs_pkg::KIND_QUERY)
      |=> !rsp_data_ff[0])
      else $error("tick or query reported an error");

   a_held_item_kept: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff)
      else $error("request register dropped an item while stalled");

   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(running_ff) && $stable(steps_ff[0]))
      else $error("motor state changed without an item moving to the response");
`endif

endmodule
